@@ src/pdcm_pkg.sv @@
// shared types, constants and the angle table for the direction change metric
package pdcm_pkg;

    localparam int CORDIC_STEPS = 62;
    localparam int STEP_W = 6;
    localparam int ANGLE_FRAC = 40;
    localparam int PRE_SHIFT = 44;
    localparam int DOT_LIMIT = 512;

    typedef logic [CORDIC_STEPS-1:0][63:0] atan_table_t;

    // one word on the queue between front and back
    typedef struct packed {
        logic [15:0] new_y;
        logic [15:0] new_x;
        logic [15:0] old_y;
        logic [15:0] old_x;
        logic        store;
        logic        last;
        logic        dropped;
    } word_t;

    // shift and subtract division, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], a[k]};
            if (r >= b) begin
                r = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] atan_inverse(input logic [63:0] m);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] n;
        t = udiv(64'd1 << 61, m);
        sum = '0;
        n = '0;
        while (t != 0) begin
            term = udiv(t, 2 * n + 1);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
            t = udiv(t, m * m);
            n = n + 1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] frac_divide(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic [63:0] q;
        r = a;
        q = '0;
        for (int k = 0; k < 13 + ANGLE_FRAC; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in units of pi/32768 with 40 fraction bits
    function automatic atan_table_t build_atan_table();
        atan_table_t tab;
        logic [63:0] quarter;
        logic [63:0] sum;
        logic [63:0] term;
        int n;
        quarter = 4 * atan_inverse(64'd5) - atan_inverse(64'd239);
        tab[0] = 64'd8192 << ANGLE_FRAC;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            sum = '0;
            n = 0;
            while (61 - i * (2 * n + 1) >= 0) begin
                term = udiv(64'd1 << (61 - i * (2 * n + 1)), 64'(2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
                n = n + 1;
            end
            tab[i] = frac_divide(sum, quarter);
        end
        return tab;
    endfunction

    localparam atan_table_t ATAN_TABLE = build_atan_table();

endpackage

@@ src/pdcm_front.sv @@
// front end: accepts points, tracks the fill count and marks dropped points
module pdcm_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      old_center_x,
    input  logic [15:0]      old_center_y,
    input  logic [15:0]      new_center_x,
    input  logic [15:0]      new_center_y,
    input  logic             last_point,
    output logic             push_valid,
    input  logic             push_ready,
    output pdcm_pkg::word_t  push_word
);
    import pdcm_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [NW-1:0] count_reg;
    logic          overflow_reg;
    logic          store;
    logic          accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign store      = count_reg < NW'(MAX_POINTS);

    always_comb
    begin
        push_word.old_x   = old_center_x;
        push_word.old_y   = old_center_y;
        push_word.new_x   = new_center_x;
        push_word.new_y   = new_center_y;
        push_word.store   = store;
        push_word.last    = last_point;
        push_word.dropped = overflow_reg || !store;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_point)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (store)
                    count_reg <= count_reg + NW'(1);
                overflow_reg <= overflow_reg || !store;
            end
        end
    end

endmodule

@@ src/pdcm_queue.sv @@
// two entry queue between front and back
module pdcm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  pdcm_pkg::word_t  push_word,
    output logic             pop_valid,
    input  logic             pop_ready,
    output pdcm_pkg::word_t  pop_word
);
    import pdcm_pkg::*;

    word_t      entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_word   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ src/pdcm_cordic.sv @@
// iterative vectoring cordic giving a rounded 16-bit binary angle
module pdcm_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    input  logic               force_zero,
    output logic [15:0]        angle,
    output logic               done
);
    import pdcm_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic signed [63:0]  x_reg;
    logic signed [63:0]  y_reg;
    logic signed [63:0]  z_reg;
    logic                fixed_reg;
    logic [15:0]         fixed_angle_reg;
    logic [15:0]         angle_reg;

    logic signed [17:0]  ex;
    logic signed [17:0]  ey;
    logic signed [17:0]  rx;
    logic signed [17:0]  ry;
    logic [1:0]          quad;
    logic                zero_case;
    logic signed [63:0]  xs;
    logic signed [63:0]  ys;
    logic signed [63:0]  tab;
    logic signed [63:0]  x_next;
    logic signed [63:0]  y_next;
    logic signed [63:0]  z_next;
    logic signed [63:0]  z_round;

    // exact quarter turns into the first quadrant
    always_comb
    begin
        ex = 18'(dx);
        ey = 18'(dy);
        if (dx > 0 && dy >= 0)
        begin
            rx = ex;
            ry = ey;
            quad = 2'd0;
        end
        else if (dy > 0 && dx <= 0)
        begin
            rx = ey;
            ry = -ex;
            quad = 2'd1;
        end
        else if (dx < 0 && dy <= 0)
        begin
            rx = -ex;
            ry = -ey;
            quad = 2'd2;
        end
        else
        begin
            rx = -ey;
            ry = ex;
            quad = 2'd3;
        end
        zero_case = force_zero || (dx == 17'sd0 && dy == 17'sd0);
    end

    always_comb
    begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        tab = $signed(ATAN_TABLE[step_reg]);
        if (!y_reg[63])
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + tab;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - tab;
        end
        z_round = z_next + (64'sd1 <<< (ANGLE_FRAC - 1));
    end

    assign angle = angle_reg;
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                done_reg <= step_reg == STEP_W'(CORDIC_STEPS - 1);
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    busy_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg           <= 64'(rx) <<< PRE_SHIFT;
            y_reg           <= 64'(ry) <<< PRE_SHIFT;
            z_reg           <= $signed({8'b0, quad, 54'b0});
            fixed_reg       <= zero_case || ry == 18'sd0;
            fixed_angle_reg <= zero_case ? 16'd0 : {quad, 14'b0};
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                angle_reg <= fixed_reg ? fixed_angle_reg : z_round[55:40];
        end
    end

endmodule

@@ src/pdcm_divsqrt.sv @@
// restoring divider followed by a bit-pair square root
module pdcm_divsqrt #(
    parameter int CW = 52,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [15:0]   root,
    output logic          done
);
    localparam int QW = (CW + 1) / 2;
    localparam int SW = 2 * QW;
    localparam int CNTW = $clog2(CW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT
    } state_t;

    state_t          state_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0]   q_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   div_reg;
    logic [SW-1:0]   v_reg;
    logic [SW-1:0]   res_reg;
    logic [SW-1:0]   bit_reg;
    logic [15:0]     root_reg;
    logic            done_reg;

    logic [DW:0]     rem_sh;
    logic            ge;
    logic [SW-1:0]   trial;

    assign rem_sh = {rem_reg[DW-1:0], q_reg[CW-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};
    assign trial  = res_reg + bit_reg;
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    done_reg <= 1'b0;
                    cnt_reg  <= cnt_reg + CNTW'(1);
                    if (cnt_reg == CNTW'(CW - 1))
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= '0;
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg  <= cnt_reg + CNTW'(1);
                    done_reg <= cnt_reg == CNTW'(QW - 1);
                    if (cnt_reg == CNTW'(QW - 1))
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                q_reg   <= dividend;
                div_reg <= divisor;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? rem_sh - {1'b0, div_reg} : rem_sh;
                q_reg   <= {q_reg[CW-2:0], ge};
                if (cnt_reg == CNTW'(CW - 1))
                begin
                    v_reg   <= SW'({q_reg[CW-2:0], ge});
                    res_reg <= '0;
                    bit_reg <= SW'(1) << (SW - 2);
                end
            end
            ST_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                    if (cnt_reg == CNTW'(QW - 1))
                        root_reg <= 16'((res_reg >> 1) + bit_reg);
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                    if (cnt_reg == CNTW'(QW - 1))
                        root_reg <= 16'(res_reg >> 1);
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

endmodule

@@ src/pdcm_back.sv @@
// back end: point store, pair pass over both layouts and the final roots
module pdcm_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  pdcm_pkg::word_t  pop_word,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      direction_change,
    output logic [15:0]      angle_deviation,
    output logic             points_dropped
);
    import pdcm_pkg::*;

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int S1W = 16 + NW;
    localparam int S2W = 31 + NW;
    localparam int PW  = 31 + 2 * NW;
    localparam int CW  = 31 + 3 * NW;
    localparam int DW  = 3 * NW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_ROW_LAT,
        S_COL,
        S_COL_LAT,
        S_START,
        S_RUN,
        S_ROW_END,
        S_ROW_ACC,
        S_NM,
        S_NMM,
        S_DIV_C,
        S_WAIT_C,
        S_DIV_P,
        S_WAIT_P,
        S_DONE
    } state_t;

    logic [63:0]            mem [MAX_POINTS];
    logic [63:0]            rd_data_reg;
    logic [AW-1:0]          rd_addr;

    state_t                 state_reg;
    logic [NW-1:0]          wr_count_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          m_reg;
    logic [NW-1:0]          i_reg;
    logic [NW-1:0]          j_reg;
    logic [63:0]            pi_reg;
    logic [3:0][31:0]       prod_reg;
    logic signed [16:0]     dx_old_reg;
    logic signed [16:0]     dy_old_reg;
    logic signed [16:0]     dx_new_reg;
    logic signed [16:0]     dy_new_reg;
    logic signed [S1W-1:0]  s1_reg;
    logic [S2W-1:0]         s2_reg;
    logic [CW-1:0]          s1sq_reg;
    logic [CW-1:0]          ms2_reg;
    logic [CW-1:0]          csum_reg;
    logic [PW-1:0]          psum_reg;
    logic [2*NW-1:0]        nm_reg;
    logic [DW-1:0]          nmm_reg;
    logic [15:0]            change_reg;
    logic [15:0]            dev_reg;
    logic                   drop_reg;
    logic                   out_valid_reg;
    logic [15:0]            out_change_reg;
    logic [15:0]            out_dev_reg;
    logic                   out_drop_reg;

    logic                   pop;
    logic [NW-1:0]          n_calc;
    logic                   cor_start;
    logic                   zero_old;
    logic                   zero_new;
    logic [15:0]            angle_old;
    logic [15:0]            angle_new;
    logic                   done_old;
    logic                   done_new;
    logic signed [15:0]     d;
    logic [31:0]            d_sq;
    logic [S1W-1:0]         s1_abs;
    logic                   ds_start;
    logic [CW-1:0]          ds_dividend;
    logic [DW-1:0]          ds_divisor;
    logic [15:0]            ds_root;
    logic                   ds_done;
    logic                   j_last;

    assign pop_ready = state_reg == S_IDLE;
    assign pop       = pop_valid && pop_ready;
    assign n_calc    = wr_count_reg + NW'(pop_word.store);
    assign rd_addr   = (state_reg == S_ROW) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign j_last    = (j_reg + NW'(1)) == n_reg;

    // dot products of the two points, raw q0.32 products
    assign zero_old  = ({1'b0, prod_reg[0]} + {1'b0, prod_reg[1]}) <= 33'(DOT_LIMIT);
    assign zero_new  = ({1'b0, prod_reg[2]} + {1'b0, prod_reg[3]}) <= 33'(DOT_LIMIT);
    assign cor_start = state_reg == S_START;

    assign d      = $signed(angle_old - angle_new);
    assign d_sq   = 32'(d * d);
    assign s1_abs = s1_reg[S1W-1] ? S1W'(-s1_reg) : S1W'(s1_reg);

    assign ds_start    = (state_reg == S_DIV_C) || (state_reg == S_DIV_P);
    assign ds_dividend = (state_reg == S_DIV_P) ? CW'(psum_reg) : csum_reg;
    assign ds_divisor  = (state_reg == S_DIV_P) ? DW'(nm_reg) : nmm_reg;

    assign out_valid        = out_valid_reg;
    assign direction_change = out_change_reg;
    assign angle_deviation  = out_dev_reg;
    assign points_dropped   = out_drop_reg;

    pdcm_cordic u_cordic_old (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cor_start),
        .dx         (dx_old_reg),
        .dy         (dy_old_reg),
        .force_zero (zero_old),
        .angle      (angle_old),
        .done       (done_old)
    );

    pdcm_cordic u_cordic_new (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cor_start),
        .dx         (dx_new_reg),
        .dy         (dy_new_reg),
        .force_zero (zero_new),
        .angle      (angle_new),
        .done       (done_new)
    );

    pdcm_divsqrt #(
        .CW (CW),
        .DW (DW)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ds_start),
        .dividend (ds_dividend),
        .divisor  (ds_divisor),
        .root     (ds_root),
        .done     (ds_done)
    );

    always_ff @(posedge clk)
    begin
        if (pop && pop_word.store)
            mem[wr_count_reg[AW-1:0]] <= {pop_word.new_y, pop_word.new_x,
                                          pop_word.old_y, pop_word.old_x};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_count_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (pop_word.last)
                        begin
                            wr_count_reg <= '0;
                            n_reg        <= n_calc;
                            m_reg        <= n_calc - NW'(1);
                            drop_reg     <= pop_word.dropped;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            s1_reg       <= '0;
                            s2_reg       <= '0;
                            csum_reg     <= '0;
                            psum_reg     <= '0;
                            if (n_calc <= NW'(1))
                            begin
                                change_reg <= '0;
                                dev_reg    <= '0;
                                state_reg  <= S_DONE;
                            end
                            else
                                state_reg <= S_ROW;
                        end
                        else
                            wr_count_reg <= n_calc;
                    end
                end
                S_ROW:
                begin
                    state_reg <= S_ROW_LAT;
                end
                S_ROW_LAT:
                begin
                    pi_reg    <= rd_data_reg;
                    state_reg <= S_COL;
                end
                S_COL:
                begin
                    // diagonal pairs are skipped
                    if (j_reg == i_reg)
                    begin
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_ROW_END;
                        end
                        else
                            j_reg <= j_reg + NW'(1);
                    end
                    else
                        state_reg <= S_COL_LAT;
                end
                S_COL_LAT:
                begin
                    prod_reg[0] <= pi_reg[15:0] * rd_data_reg[15:0];
                    prod_reg[1] <= pi_reg[31:16] * rd_data_reg[31:16];
                    prod_reg[2] <= pi_reg[47:32] * rd_data_reg[47:32];
                    prod_reg[3] <= pi_reg[63:48] * rd_data_reg[63:48];
                    dx_old_reg  <= $signed({1'b0, rd_data_reg[15:0]})
                                   - $signed({1'b0, pi_reg[15:0]});
                    dy_old_reg  <= $signed({1'b0, rd_data_reg[31:16]})
                                   - $signed({1'b0, pi_reg[31:16]});
                    dx_new_reg  <= $signed({1'b0, rd_data_reg[47:32]})
                                   - $signed({1'b0, pi_reg[47:32]});
                    dy_new_reg  <= $signed({1'b0, rd_data_reg[63:48]})
                                   - $signed({1'b0, pi_reg[63:48]});
                    state_reg   <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (done_old && done_new)
                    begin
                        s1_reg <= s1_reg + S1W'(d);
                        s2_reg <= s2_reg + S2W'(d_sq);
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_ROW_END;
                        end
                        else
                        begin
                            j_reg     <= j_reg + NW'(1);
                            state_reg <= S_COL;
                        end
                    end
                end
                S_ROW_END:
                begin
                    s1sq_reg  <= CW'(s1_abs) * CW'(s1_abs);
                    ms2_reg   <= CW'(m_reg) * CW'(s2_reg);
                    state_reg <= S_ROW_ACC;
                end
                S_ROW_ACC:
                begin
                    csum_reg <= csum_reg + ms2_reg - s1sq_reg;
                    psum_reg <= psum_reg + PW'(s2_reg);
                    s1_reg   <= '0;
                    s2_reg   <= '0;
                    if ((i_reg + NW'(1)) == n_reg)
                        state_reg <= S_NM;
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_ROW;
                    end
                end
                S_NM:
                begin
                    nm_reg    <= n_reg * m_reg;
                    state_reg <= S_NMM;
                end
                S_NMM:
                begin
                    nmm_reg   <= DW'(nm_reg) * DW'(m_reg);
                    state_reg <= S_DIV_C;
                end
                S_DIV_C:
                begin
                    state_reg <= S_WAIT_C;
                end
                S_WAIT_C:
                begin
                    if (ds_done)
                    begin
                        change_reg <= ds_root;
                        state_reg  <= S_DIV_P;
                    end
                end
                S_DIV_P:
                begin
                    state_reg <= S_WAIT_P;
                end
                S_WAIT_P:
                begin
                    if (ds_done)
                    begin
                        dev_reg   <= ds_root;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // wait for the output word slot
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_change_reg <= change_reg;
                        out_dev_reg    <= dev_reg;
                        out_drop_reg   <= drop_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/pairwise_direction_change_metric.sv @@
// pairwise direction change metric, top level
// each point word is taken through a two word queue, which fills while the back end is busy
// when N exceeds one, the last word starts a pass of N*(N-1) pairs, each run through the 62 step
// cordic pair, with a row sum after each row; then two divide and square root runs
// rst_n clears counts, queue and handshakes; the point store is not cleared
module pairwise_direction_change_metric #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] old_center_x,
    input  logic [15:0] old_center_y,
    input  logic [15:0] new_center_x,
    input  logic [15:0] new_center_y,
    input  logic        last_point,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] direction_change,
    output logic [15:0] angle_deviation,
    output logic        points_dropped
);
    import pdcm_pkg::*;

    word_t push_word;
    word_t pop_word;
    logic  push_valid;
    logic  push_ready;
    logic  pop_valid;
    logic  pop_ready;

    pdcm_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .old_center_x (old_center_x),
        .old_center_y (old_center_y),
        .new_center_x (new_center_x),
        .new_center_y (new_center_y),
        .last_point   (last_point),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_word    (push_word)
    );

    pdcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    pdcm_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_word         (pop_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .direction_change (direction_change),
        .angle_deviation  (angle_deviation),
        .points_dropped   (points_dropped)
    );

endmodule
